FILE: src/bpdm_pkg.sv
// Shared types and constants for the button packet drive mixer.
// No dependencies; imported by every module of the block.
package bpdm_pkg;

  localparam int FRAME_LEN       = 4;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int BYTE_W  = 8;
  localparam int DUTY_W  = 10;
  localparam int DIR_W   = 2;
  localparam int PINS_W  = 4;
  localparam int BTN_N   = 4;
  localparam int CFG_IDX_W = 1;

  localparam logic [BYTE_W-1:0] CH_START = 8'h21; // '!'
  localparam logic [BYTE_W-1:0] CH_TAG   = 8'h42; // 'B'
  localparam logic [BYTE_W-1:0] CH_FWD   = 8'h35; // '5'
  localparam logic [BYTE_W-1:0] CH_BACK  = 8'h36; // '6'
  localparam logic [BYTE_W-1:0] CH_LEFT  = 8'h37; // '7'
  localparam logic [BYTE_W-1:0] CH_RIGHT = 8'h38; // '8'
  localparam logic [BYTE_W-1:0] CH_PRESS = 8'h31; // '1'

  localparam logic [DUTY_W-1:0] PWM_TOP        = 10'd1000;
  localparam logic [DUTY_W-1:0] FULL_SPEED_RST = 10'd700;
  localparam logic [DUTY_W-1:0] TURN_SPEED_RST = 10'd200;

  // held-button bit positions
  localparam int BTN_FWD   = 0;
  localparam int BTN_BACK  = 1;
  localparam int BTN_LEFT  = 2;
  localparam int BTN_RIGHT = 3;

  localparam logic signed [DIR_W-1:0] DIR_FWD  = 2'sb01;
  localparam logic signed [DIR_W-1:0] DIR_REV  = 2'sb11;
  localparam logic signed [DIR_W-1:0] DIR_STOP = 2'sb00;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FULL_SPEED = 1'b0,
    CFG_TURN_SPEED = 1'b1
  } cfg_idx_t;

  // one button update handed from the frame parser to the mixer
  typedef struct packed {
    logic [BTN_N-1:0] mask;
    logic             press;
  } cmd_t;

endpackage

FILE: src/bpdm_front.sv
// Frame parser: gathers '!'-framed bytes and emits one button command per
// accepted frame. Depends on bpdm_pkg.
module bpdm_front import bpdm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [BYTE_W-1:0] in_rx_data,
  input  logic              q_full,
  output logic              q_push,
  output cmd_t              q_cmd
);

  // one state per byte position of the frame
  typedef enum logic [1:0] {
    F_IDLE,
    F_TAG,
    F_BTN,
    F_LAST
  } fstate_t;

  fstate_t           state_r, state_nxt;
  logic              tag_ok_r;
  logic [BYTE_W-1:0] btn_r;
  logic              accept;
  logic              is_start;
  logic [BTN_N-1:0]  mask;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign is_start = (in_rx_data == CH_START);

  always_comb begin
    mask = '0;
    unique case (btn_r)
      CH_FWD:   mask[BTN_FWD]   = 1'b1;
      CH_BACK:  mask[BTN_BACK]  = 1'b1;
      CH_LEFT:  mask[BTN_LEFT]  = 1'b1;
      CH_RIGHT: mask[BTN_RIGHT] = 1'b1;
      default:  mask = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    q_push    = 1'b0;
    if (accept) begin
      if (is_start) begin
        state_nxt = F_TAG;
      end else begin
        unique case (state_r)
          F_IDLE: state_nxt = F_IDLE;
          F_TAG:  state_nxt = F_BTN;
          F_BTN:  state_nxt = F_LAST;
          F_LAST: begin
            state_nxt = F_IDLE;
            q_push    = tag_ok_r;
          end
          default: state_nxt = F_IDLE;
        endcase
      end
    end
  end

  assign q_cmd.mask  = mask;
  assign q_cmd.press = (in_rx_data == CH_PRESS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    if (accept && !is_start) begin
      if (state_r == F_TAG) tag_ok_r <= (in_rx_data == CH_TAG);
      if (state_r == F_BTN) btn_r <= in_rx_data;
    end
  end

endmodule

FILE: src/bpdm_queue.sv
// Small FIFO of button commands between parser and mixer.
// Depends on bpdm_pkg for cmd_t.
module bpdm_queue import bpdm_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic full,
  output logic empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  cmd_t          mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
    if (push) mem_r[wr_ptr_r] <= push_cmd;
  end

endmodule

FILE: src/bpdm_back.sv
// Mixer: applies button commands to the held flags, mixes motor drive and
// holds the result item in the output register. Also holds the speed registers.
// Depends on bpdm_pkg.
module bpdm_back import bpdm_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [DUTY_W-1:0]       cfg_data,
  input  logic                    q_empty,
  input  cmd_t                    q_cmd,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [DIR_W-1:0] out_left_dir,
  output logic signed [DIR_W-1:0] out_right_dir,
  output logic [DUTY_W-1:0]       out_left_duty,
  output logic [DUTY_W-1:0]       out_right_duty,
  output logic [PINS_W-1:0]       out_bridge_pins
);

  logic [DUTY_W-1:0]       full_speed_r, turn_speed_r;
  logic [BTN_N-1:0]        held_r, held_nxt;
  logic                    out_valid_r;
  logic signed [DIR_W-1:0] ldir_r, rdir_r, ldir_nxt, rdir_nxt;
  logic [DUTY_W-1:0]       lduty_r, rduty_r, lduty_nxt, rduty_nxt;
  logic [PINS_W-1:0]       pins_r, pins_nxt;
  logic [DUTY_W-1:0]       fs, ts;

  assign cfg_ready = 1'b1;
  assign q_pop     = !q_empty && (!out_valid_r || out_ready);

  assign fs = (full_speed_r > PWM_TOP) ? PWM_TOP : full_speed_r;
  assign ts = (turn_speed_r > PWM_TOP) ? PWM_TOP : turn_speed_r;

  assign held_nxt = q_cmd.press ? (held_r | q_cmd.mask) : (held_r & ~q_cmd.mask);

  always_comb begin
    ldir_nxt  = DIR_STOP;
    rdir_nxt  = DIR_STOP;
    lduty_nxt = '0;
    rduty_nxt = '0;
    if (held_nxt[BTN_FWD] || held_nxt[BTN_BACK]) begin
      ldir_nxt  = held_nxt[BTN_FWD] ? DIR_FWD : DIR_REV;
      rdir_nxt  = ldir_nxt;
      lduty_nxt = fs;
      rduty_nxt = fs;
      if (held_nxt[BTN_LEFT])       lduty_nxt = ts;
      else if (held_nxt[BTN_RIGHT]) rduty_nxt = ts;
    end else if (held_nxt[BTN_LEFT]) begin
      ldir_nxt  = DIR_REV;
      rdir_nxt  = DIR_FWD;
      lduty_nxt = fs;
      rduty_nxt = fs;
    end else if (held_nxt[BTN_RIGHT]) begin
      ldir_nxt  = DIR_FWD;
      rdir_nxt  = DIR_REV;
      lduty_nxt = fs;
      rduty_nxt = fs;
    end
    // right motor pins are wired swapped
    pins_nxt[0] = (ldir_nxt == DIR_FWD);
    pins_nxt[1] = (ldir_nxt == DIR_REV);
    pins_nxt[2] = (rdir_nxt == DIR_REV);
    pins_nxt[3] = (rdir_nxt == DIR_FWD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_speed_r <= FULL_SPEED_RST;
      turn_speed_r <= TURN_SPEED_RST;
      held_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_FULL_SPEED: full_speed_r <= cfg_data;
          CFG_TURN_SPEED: turn_speed_r <= cfg_data;
          default: ;
        endcase
      end
      if (q_pop) begin
        held_r      <= held_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (q_pop) begin
      ldir_r  <= ldir_nxt;
      rdir_r  <= rdir_nxt;
      lduty_r <= lduty_nxt;
      rduty_r <= rduty_nxt;
      pins_r  <= pins_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_dir    = ldir_r;
  assign out_right_dir   = rdir_r;
  assign out_left_duty   = lduty_r;
  assign out_right_duty  = rduty_r;
  assign out_bridge_pins = pins_r;

endmodule

FILE: src/button_packet_drive_mixer_unit.sv
// Button packet drive mixer, top level: parser, command queue and mixer.
// Depends on bpdm_pkg, bpdm_front, bpdm_queue and bpdm_back.
//
// Takes one received byte per item, at up to one item per clock. A frame is
// '!' followed by three bytes; a complete frame tagged 'B' updates at most one
// held button and yields one drive result, which passes through the command
// queue and then the mixer's output register. Other bytes yield nothing. The
// parser stalls only when the QUEUE_DEPTH-entry command queue is full, which
// happens only while the output is held off. Speed registers are written over
// the cfg channel (always ready); the speeds applied are clamped to the PWM
// period of 1000.
module button_packet_drive_mixer_unit import bpdm_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [BYTE_W-1:0]       in_rx_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [DIR_W-1:0] out_left_dir,
  output logic signed [DIR_W-1:0] out_right_dir,
  output logic [DUTY_W-1:0]       out_left_duty,
  output logic [DUTY_W-1:0]       out_right_duty,
  output logic [PINS_W-1:0]       out_bridge_pins,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [DUTY_W-1:0]       cfg_data
);

  cmd_t push_cmd, pop_cmd;
  logic push, pop, full, empty;

  bpdm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_data (in_rx_data),
    .q_full     (full),
    .q_push     (push),
    .q_cmd      (push_cmd)
  );

  bpdm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .full     (full),
    .empty    (empty)
  );

  bpdm_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_empty         (empty),
    .q_cmd           (pop_cmd),
    .q_pop           (pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_left_dir    (out_left_dir),
    .out_right_dir   (out_right_dir),
    .out_left_duty   (out_left_duty),
    .out_right_duty  (out_right_duty),
    .out_bridge_pins (out_bridge_pins)
  );

endmodule

FILE: src/bpdm_checker.sv
// Port-level checks for the button packet drive mixer, bound to the top level.
// Depends on bpdm_pkg and button_packet_drive_mixer_unit.
module bpdm_checker import bpdm_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [DIR_W-1:0] out_left_dir,
  input logic signed [DIR_W-1:0] out_right_dir,
  input logic [DUTY_W-1:0]       out_left_duty,
  input logic [DUTY_W-1:0]       out_right_duty,
  input logic [PINS_W-1:0]       out_bridge_pins
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result item shown right after reset");

  a_left_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_left_dir == DIR_STOP) == (out_bridge_pins[1:0] == 2'b00))
                  && (out_bridge_pins[1:0] != 2'b11))
    else $error("left bridge pins disagree with left direction");

  a_right_pins: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_right_dir == DIR_STOP) == (out_bridge_pins[3:2] == 2'b00))
                  && (out_bridge_pins[3:2] != 2'b11))
    else $error("right bridge pins disagree with right direction");

  a_duty_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_left_duty <= PWM_TOP) && (out_right_duty <= PWM_TOP))
    else $error("duty above PWM period");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_left_duty)
                                && $stable(out_bridge_pins))
    else $error("stalled result item changed");

endmodule

bind button_packet_drive_mixer_unit bpdm_checker u_bpdm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_left_dir    (out_left_dir),
  .out_right_dir   (out_right_dir),
  .out_left_duty   (out_left_duty),
  .out_right_duty  (out_right_duty),
  .out_bridge_pins (out_bridge_pins)
);

FILE: tb/button_packet_drive_mixer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for button_packet_drive_mixer_unit: directed frames, then
// random frame streams under several speed settings, checked against a local predictor.
// Depends on bpdm_pkg and the button_packet_drive_mixer_unit RTL.
module button_packet_drive_mixer_unit_tb;
  import bpdm_pkg::*;

  localparam int NUM_PHASES      = 6;
  localparam int PHASE_ITEMS     = 125;
  localparam int PRESSURE_FRAMES = 8;
  localparam int LONG_HOLD       = 60;
  localparam int SETTLE_CYCLES   = 4;
  localparam int REPORT_LIMIT    = 10;

  // bytes outside the package set
  localparam logic [BYTE_W-1:0] CH_BAD_TAG = 8'h41; // 'A'
  localparam logic [BYTE_W-1:0] CH_UNKNOWN = 8'h39; // '9'
  localparam logic [BYTE_W-1:0] CH_RELEASE = 8'h30; // '0'
  localparam logic [BYTE_W-1:0] CH_IDLE    = 8'hFF;

  localparam logic [BYTE_W-1:0] BUTTONS [4] = '{CH_FWD, CH_BACK, CH_LEFT, CH_RIGHT};
  localparam logic [DUTY_W-1:0] FULL_SET [4] = '{10'd700, 10'd1023, 10'd0, 10'd1000};
  localparam logic [DUTY_W-1:0] TURN_SET [4] = '{10'd200, 10'd0, 10'd1023, 10'd1};

  typedef struct packed {
    logic signed [DIR_W-1:0] left_dir;
    logic signed [DIR_W-1:0] right_dir;
    logic [DUTY_W-1:0]       left_duty;
    logic [DUTY_W-1:0]       right_duty;
    logic [PINS_W-1:0]       pins;
  } drive_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rx;
    logic              has_drive;
    drive_t            drive;
  } stim_row_t;

  localparam drive_t NO_DRIVE = '0;
  localparam drive_t FWD_STRAIGHT = '{DIR_FWD, DIR_FWD, 10'd700, 10'd700, 4'b1001};
  localparam drive_t FWD_RIGHT    = '{DIR_FWD, DIR_FWD, 10'd700, 10'd200, 4'b1001};
  localparam drive_t BACK_RIGHT   = '{DIR_REV, DIR_REV, 10'd700, 10'd200, 4'b0110};

  // reset speeds apply throughout this table
  localparam int DIR_ROWS = 28;
  localparam stim_row_t DIRECTED_ROWS [DIR_ROWS] = '{
    '{CH_IDLE,    1'b0, NO_DRIVE},
    '{CH_START,   1'b0, NO_DRIVE},
    '{CH_TAG,     1'b0, NO_DRIVE},
    '{CH_FWD,     1'b0, NO_DRIVE},
    '{CH_PRESS,   1'b1, FWD_STRAIGHT},
    '{CH_START,   1'b0, NO_DRIVE},
    '{CH_TAG,     1'b0, NO_DRIVE},
    '{CH_RIGHT,   1'b0, NO_DRIVE},
    '{CH_PRESS,   1'b1, FWD_RIGHT},
    // wrong tag: dropped
    '{CH_START,   1'b0, NO_DRIVE},
    '{CH_BAD_TAG, 1'b0, NO_DRIVE},
    '{CH_LEFT,    1'b0, NO_DRIVE},
    '{CH_PRESS,   1'b0, NO_DRIVE},
    // start byte in last position reopens the frame
    '{CH_START,   1'b0, NO_DRIVE},
    '{CH_TAG,     1'b0, NO_DRIVE},
    '{CH_LEFT,    1'b0, NO_DRIVE},
    '{CH_START,   1'b0, NO_DRIVE},
    '{CH_TAG,     1'b0, NO_DRIVE},
    '{CH_BACK,    1'b0, NO_DRIVE},
    '{CH_PRESS,   1'b1, FWD_RIGHT},
    '{CH_START,   1'b0, NO_DRIVE},
    '{CH_TAG,     1'b0, NO_DRIVE},
    '{CH_FWD,     1'b0, NO_DRIVE},
    '{CH_RELEASE, 1'b1, BACK_RIGHT},
    // unknown button: flags unchanged, still a result
    '{CH_START,   1'b0, NO_DRIVE},
    '{CH_TAG,     1'b0, NO_DRIVE},
    '{CH_UNKNOWN, 1'b0, NO_DRIVE},
    '{CH_PRESS,   1'b1, BACK_RIGHT}
  };

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [BYTE_W-1:0]       in_rx_data = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [DIR_W-1:0] out_left_dir;
  logic signed [DIR_W-1:0] out_right_dir;
  logic [DUTY_W-1:0]       out_left_duty;
  logic [DUTY_W-1:0]       out_right_duty;
  logic [PINS_W-1:0]       out_bridge_pins;
  logic                    cfg_valid = 1'b0;
  logic                    cfg_ready;
  cfg_idx_t                cfg_index = CFG_FULL_SPEED;
  logic [DUTY_W-1:0]       cfg_data = '0;

  button_packet_drive_mixer_unit u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_data     (in_rx_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_left_dir   (out_left_dir),
    .out_right_dir  (out_right_dir),
    .out_left_duty  (out_left_duty),
    .out_right_duty (out_right_duty),
    .out_bridge_pins(out_bridge_pins),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // predictor state
  logic [DUTY_W-1:0] full_speed_q = FULL_SPEED_RST;
  logic [DUTY_W-1:0] turn_speed_q = TURN_SPEED_RST;
  int                frame_pos = 0;
  logic [BYTE_W-1:0] frame_buf [FRAME_LEN-1];
  logic [BTN_N-1:0]  held = '0;

  drive_t pending_drives [$];
  drive_t want;
  int     mismatches = 0;
  int     frame_items = 0;
  bit     send_idle_en = 1'b1;
  logic   recv_idle_en = 1'b1;
  int     hold_reqs = 0;
  int     hold_seen = 0;
  int     stall_left = 0;

  // Consumes one byte; returns 1 with the drive when a tagged frame completes.
  function automatic bit decode_byte(input logic [BYTE_W-1:0] b, output drive_t d);
    logic [BTN_N-1:0]  sel;
    logic [DUTY_W-1:0] fs;
    logic [DUTY_W-1:0] ts;
    d = NO_DRIVE;
    if (b == CH_START) begin
      frame_pos = 1;
      return 1'b0;
    end
    if (frame_pos == 0 || frame_pos >= FRAME_LEN) begin
      frame_pos = 0;
      return 1'b0;
    end
    if (frame_pos < FRAME_LEN - 1) begin
      frame_buf[frame_pos-1] = b;
      frame_pos++;
      return 1'b0;
    end
    frame_buf[FRAME_LEN-2] = b;
    frame_pos = 0;
    if (frame_buf[0] != CH_TAG) return 1'b0;

    sel = '0;
    case (frame_buf[1])
      CH_FWD:   sel[BTN_FWD] = 1'b1;
      CH_BACK:  sel[BTN_BACK] = 1'b1;
      CH_LEFT:  sel[BTN_LEFT] = 1'b1;
      CH_RIGHT: sel[BTN_RIGHT] = 1'b1;
      default:  sel = '0;
    endcase
    if (b == CH_PRESS) held = held | sel;
    else held = held & ~sel;

    fs = (full_speed_q > PWM_TOP) ? PWM_TOP : full_speed_q;
    ts = (turn_speed_q > PWM_TOP) ? PWM_TOP : turn_speed_q;
    d.left_dir  = DIR_STOP;
    d.right_dir = DIR_STOP;
    if (held[BTN_FWD] || held[BTN_BACK]) begin
      d.left_dir   = held[BTN_FWD] ? DIR_FWD : DIR_REV;
      d.right_dir  = d.left_dir;
      d.left_duty  = fs;
      d.right_duty = fs;
      if (held[BTN_LEFT]) d.left_duty = ts;
      else if (held[BTN_RIGHT]) d.right_duty = ts;
    end else if (held[BTN_LEFT]) begin
      d.left_dir   = DIR_REV;
      d.right_dir  = DIR_FWD;
      d.left_duty  = fs;
      d.right_duty = fs;
    end else if (held[BTN_RIGHT]) begin
      d.left_dir   = DIR_FWD;
      d.right_dir  = DIR_REV;
      d.left_duty  = fs;
      d.right_duty = fs;
    end
    // right bridge is wired swapped
    d.pins[0] = (d.left_dir == DIR_FWD);
    d.pins[1] = (d.left_dir == DIR_REV);
    d.pins[2] = (d.right_dir == DIR_REV);
    d.pins[3] = (d.right_dir == DIR_FWD);
    return 1'b1;
  endfunction

  // Offers one byte, waits for it to be taken, then records its expected drive.
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed,
                           input drive_t typed_drive);
    drive_t d;
    bit     got;
    if (send_idle_en && $urandom_range(0, 6) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_data <= b;
    do @(posedge clk); while (!in_ready);
    got = decode_byte(b, d);
    if (typed) pending_drives.push_back(typed_drive);
    else if (got) pending_drives.push_back(d);
  endtask

  // Mostly well-formed frames with random content; the rest noise and cut-off frames.
  task automatic send_frame(input bit clean);
    int                kind;
    int                sel;
    logic [BYTE_W-1:0] btn;
    kind = clean ? 99 : $urandom_range(0, 99);
    if (kind < 8) begin
      repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, NO_DRIVE);
    end else if (kind < 16) begin
      send_byte(CH_START, 1'b0, NO_DRIVE);
      frame_items++;
      repeat ($urandom_range(0, 2)) begin
        send_byte(8'($urandom_range(0, 255)), 1'b0, NO_DRIVE);
        frame_items++;
      end
    end else begin
      sel = $urandom_range(0, 9);
      btn = (sel < 9) ? BUTTONS[sel % 4] : 8'($urandom_range(0, 255));
      send_byte(CH_START, 1'b0, NO_DRIVE);
      send_byte(($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : CH_TAG,
                1'b0, NO_DRIVE);
      send_byte(btn, 1'b0, NO_DRIVE);
      send_byte($urandom_range(0, 1) ? CH_PRESS : 8'($urandom_range(0, 255)),
                1'b0, NO_DRIVE);
      frame_items += 4;
    end
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_speed(input cfg_idx_t idx, input logic [DUTY_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_FULL_SPEED) full_speed_q = val;
    else turn_speed_q = val;
  endtask

  // Stop offering and wait until every expected drive is back and the block is idle.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // receiver: random stall bursts plus an occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (hold_seen != hold_reqs) begin
      hold_seen++;
      stall_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_drives.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected drive: dir %0d/%0d duty %0d/%0d pins %b",
                   out_left_dir, out_right_dir, out_left_duty, out_right_duty,
                   out_bridge_pins);
      end else begin
        want = pending_drives.pop_front();
        if (out_left_dir !== want.left_dir || out_right_dir !== want.right_dir ||
            out_left_duty !== want.left_duty || out_right_duty !== want.right_duty ||
            out_bridge_pins !== want.pins) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("drive @%0t: expected dir %0d/%0d duty %0d/%0d pins %b,",
                     $realtime, want.left_dir, want.right_dir, want.left_duty,
                     want.right_duty, want.pins,
                     " got dir %0d/%0d duty %0d/%0d pins %b",
                     out_left_dir, out_right_dir,
                     out_left_duty, out_right_duty, out_bridge_pins);
        end
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      send_byte(DIRECTED_ROWS[i].rx, DIRECTED_ROWS[i].has_drive, DIRECTED_ROWS[i].drive);
    drain();

    // back-to-back frames against a held-off output so the input side backs up
    hold_reqs <= hold_reqs + 1;
    send_idle_en = 1'b0;
    repeat (PRESSURE_FRAMES) send_frame(1'b1);
    send_idle_en = 1'b1;
    drain();

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == NUM_PHASES - 1) begin
        send_idle_en = 1'b0;
        recv_idle_en <= 1'b0;
      end
      write_speed(CFG_FULL_SPEED, (p < 4) ? FULL_SET[p] : 10'($urandom_range(0, 1023)));
      write_speed(CFG_TURN_SPEED, (p < 4) ? TURN_SET[p] : 10'($urandom_range(0, 1023)));
      cfg_valid <= 1'b0;
      frame_items = 0;
      while (frame_items < PHASE_ITEMS) send_frame(1'b0);
      drain();
    end

    if (mismatches == 0 && pending_drives.size() == 0) begin
      $display("button_packet_drive_mixer_unit: match");
    end else begin
      $display("button_packet_drive_mixer_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("button_packet_drive_mixer_unit: mismatch");
    $finish;
  end

endmodule
